@@ rtl/printer_status_reply_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the printer status reply parser
// Concurrent assertion shorthands for the one RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef PRINTER_STATUS_REPLY_PARSER_UNIT_DEFINES_SVH
`define PRINTER_STATUS_REPLY_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser package
// Shared types and character, status and offset constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prsp_pkg;

  typedef enum logic [1:0] {
    KIND_POLL = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SCAN_LEAD = 2'd0,
    SCAN_IN   = 2'd1,
    SCAN_DONE = 2'd2
  } scan_phase_t;

  localparam logic [3:0] ST_BUSY      = 4'd0;
  localparam logic [3:0] ST_OK        = 4'd1;
  localparam logic [3:0] ST_NOPAPER   = 4'd2;
  localparam logic [3:0] ST_NORIBBON  = 4'd3;
  localparam logic [3:0] ST_PENDING   = 4'd4;
  localparam logic [3:0] ST_PAUSED    = 4'd5;
  localparam logic [3:0] ST_BUFFULL   = 4'd6;
  localparam logic [3:0] ST_HWFAULT   = 4'd7;
  localparam logic [3:0] ST_HEADOPEN  = 4'd8;
  localparam logic [3:0] ST_OFFLINE   = 4'd9;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int unsigned NUM_FLAGS = 8;
  // Byte offset of each flag character, flag bit i at entry i.
  localparam logic [6:0] FLAG_OFFSET [NUM_FLAGS] = '{
    7'd5, 7'd7, 7'd18, 7'd28, 7'd30, 7'd32, 7'd43, 7'd45
  };
  localparam int unsigned FLAG_NOPAPER  = 0;
  localparam int unsigned FLAG_PAUSED   = 1;
  localparam int unsigned FLAG_BUFFULL  = 2;
  localparam int unsigned FLAG_HW_LO    = 3;
  localparam int unsigned FLAG_HW_HI    = 5;
  localparam int unsigned FLAG_HEADOPEN = 6;
  localparam int unsigned FLAG_NORIBBON = 7;

  localparam logic [6:0]  NUM_OFFSET    = 7'd14;
  localparam logic [1:0]  LINES_NEEDED  = 2'd3;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       send_query;
  } result_t;

endpackage

@@ rtl/prsp_ifs.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser channel interfaces
// Valid/ready channels for poll items, results and the timeout register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface prsp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       send_query;
  modport source (output valid, output status, output send_query, input ready);
  modport sink (input valid, input status, input send_query, output ready);
endinterface

interface prsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

@@ rtl/prsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser input stage
// Registers one incoming transaction until the parser can process it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prsp_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  prsp_in_if.sink          in_chan,
  input  logic             advance,
  output logic             item_valid,
  output prsp_pkg::item_t  item
);

  logic            valid_r;
  logic            valid_nxt;
  prsp_pkg::item_t item_r;
  logic            take;

  // The register may refill in the same cycle that it drains.
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.kind    <= prsp_pkg::kind_t'(in_chan.kind);
      item_r.rx_byte <= in_chan.rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/prsp_parse_core.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser core
// Holds the capture state and decides the result of each processed item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "printer_status_reply_parser_unit_defines.svh"

module prsp_parse_core #(
  parameter int unsigned REPLY_LIMIT = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_timeout_ticks,
  input  logic              item_valid,
  input  prsp_pkg::item_t   item,
  output prsp_pkg::result_t result
);

  localparam logic [6:0] LIMIT = 7'(REPLY_LIMIT);

  logic                  waiting_r, waiting_nxt;
  logic [6:0]            byte_count_r, byte_count_nxt;
  logic [1:0]            line_count_r, line_count_nxt;
  logic [7:0]            flag_bits_r, flag_bits_nxt;
  prsp_pkg::scan_phase_t scan_phase_r, scan_phase_nxt;
  logic                  nonzero_r, nonzero_nxt;
  logic [15:0]           elapsed_r, elapsed_nxt;
  logic [15:0]           timeout_r;

  function automatic logic [3:0] priority_status(input logic [7:0] flags,
                                                 input logic nonzero);
    logic [3:0] st;
    if (flags[prsp_pkg::FLAG_NOPAPER]) begin
      st = prsp_pkg::ST_NOPAPER;
    end else if (flags[prsp_pkg::FLAG_NORIBBON]) begin
      st = prsp_pkg::ST_NORIBBON;
    end else if (nonzero) begin
      st = prsp_pkg::ST_PENDING;
    end else if (flags[prsp_pkg::FLAG_PAUSED]) begin
      st = prsp_pkg::ST_PAUSED;
    end else if (flags[prsp_pkg::FLAG_BUFFULL]) begin
      st = prsp_pkg::ST_BUFFULL;
    end else if (|flags[prsp_pkg::FLAG_HW_HI:prsp_pkg::FLAG_HW_LO]) begin
      st = prsp_pkg::ST_HWFAULT;
    end else if (flags[prsp_pkg::FLAG_HEADOPEN]) begin
      st = prsp_pkg::ST_HEADOPEN;
    end else begin
      st = prsp_pkg::ST_OK;
    end
    return st;
  endfunction

  logic c_digit, c_blank, c_sign, c_zero;

  assign c_digit = (item.rx_byte >= prsp_pkg::CHAR_ZERO) &&
                   (item.rx_byte <= prsp_pkg::CHAR_NINE);
  assign c_blank = (item.rx_byte == prsp_pkg::CHAR_SPACE) ||
                   ((item.rx_byte >= prsp_pkg::CHAR_TAB) &&
                    (item.rx_byte <= prsp_pkg::CHAR_CR));
  assign c_sign  = (item.rx_byte == prsp_pkg::CHAR_PLUS) ||
                   (item.rx_byte == prsp_pkg::CHAR_MINUS);
  assign c_zero  = (item.rx_byte == prsp_pkg::CHAR_ZERO);

  always_comb begin
    waiting_nxt       = waiting_r;
    byte_count_nxt    = byte_count_r;
    line_count_nxt    = line_count_r;
    flag_bits_nxt     = flag_bits_r;
    scan_phase_nxt    = scan_phase_r;
    nonzero_nxt       = nonzero_r;
    elapsed_nxt       = elapsed_r;
    result.status     = prsp_pkg::ST_BUSY;
    result.send_query = 1'b0;
    if (item_valid) begin
      unique case (item.kind)
        prsp_pkg::KIND_POLL: begin
          if (!waiting_r) begin
            waiting_nxt       = 1'b1;
            byte_count_nxt    = '0;
            line_count_nxt    = '0;
            flag_bits_nxt     = '0;
            scan_phase_nxt    = prsp_pkg::SCAN_LEAD;
            nonzero_nxt       = 1'b0;
            elapsed_nxt       = '0;
            result.send_query = 1'b1;
          end
        end
        prsp_pkg::KIND_BYTE: begin
          if (waiting_r) begin
            if (byte_count_r >= LIMIT) begin
              waiting_nxt   = 1'b0;
              result.status = prsp_pkg::ST_OFFLINE;
            end else begin
              for (int i = 0; i < prsp_pkg::NUM_FLAGS; i++) begin
                if ((byte_count_r == prsp_pkg::FLAG_OFFSET[i]) && !c_zero) begin
                  flag_bits_nxt[i] = 1'b1;
                end
              end
              // Number scan: skip leading blanks, accept one sign, then digits.
              if (byte_count_r >= prsp_pkg::NUM_OFFSET) begin
                if ((scan_phase_r == prsp_pkg::SCAN_LEAD) && c_blank) begin
                  scan_phase_nxt = prsp_pkg::SCAN_LEAD;
                end else if ((scan_phase_r == prsp_pkg::SCAN_LEAD) && c_sign) begin
                  scan_phase_nxt = prsp_pkg::SCAN_IN;
                end else if (scan_phase_r != prsp_pkg::SCAN_DONE) begin
                  if (c_digit) begin
                    scan_phase_nxt = prsp_pkg::SCAN_IN;
                    if (!c_zero) begin
                      nonzero_nxt = 1'b1;
                    end
                  end else begin
                    scan_phase_nxt = prsp_pkg::SCAN_DONE;
                  end
                end
              end
              byte_count_nxt = byte_count_r + 7'd1;
              if (item.rx_byte == prsp_pkg::CHAR_LF) begin
                line_count_nxt = line_count_r + 2'd1;
                if (line_count_nxt == prsp_pkg::LINES_NEEDED) begin
                  result.status = priority_status(flag_bits_nxt, nonzero_nxt);
                  waiting_nxt   = 1'b0;
                end
              end
            end
          end
        end
        prsp_pkg::KIND_TICK: begin
          if (waiting_r) begin
            if (elapsed_r != prsp_pkg::ELAPSED_MAX) begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
            if (elapsed_nxt > timeout_r) begin
              waiting_nxt   = 1'b0;
              result.status = prsp_pkg::ST_OFFLINE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r    <= 1'b0;
      byte_count_r <= '0;
      line_count_r <= '0;
      flag_bits_r  <= '0;
      scan_phase_r <= prsp_pkg::SCAN_LEAD;
      nonzero_r    <= 1'b0;
      elapsed_r    <= '0;
      timeout_r    <= prsp_pkg::TIMEOUT_RESET;
    end else begin
      waiting_r    <= waiting_nxt;
      byte_count_r <= byte_count_nxt;
      line_count_r <= line_count_nxt;
      flag_bits_r  <= flag_bits_nxt;
      scan_phase_r <= scan_phase_nxt;
      nonzero_r    <= nonzero_nxt;
      elapsed_r    <= elapsed_nxt;
      if (cfg_write) begin
        timeout_r <= cfg_timeout_ticks;
      end
    end
  end

  `PRSP_ASSERT_NEXT(a_final_status_goes_idle, clk, rst_n, item_valid && (result.status != prsp_pkg::ST_BUSY), !waiting_r, "final status did not return the parser to idle")
  `PRSP_ASSERT_NEXT(a_query_clears_capture, clk, rst_n, item_valid && result.send_query, waiting_r && (byte_count_r == '0) && (flag_bits_r == '0), "query start did not clear capture")
  `PRSP_ASSERT_NOW(a_byte_count_bounded, clk, rst_n, 1'b1, byte_count_r <= LIMIT, "byte count passed the reply limit")
  `PRSP_ASSERT_NOW(a_no_fourth_line, clk, rst_n, waiting_r, line_count_r != prsp_pkg::LINES_NEEDED, "still waiting after the third line feed")

endmodule

@@ rtl/prsp_out_stage.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser output stage
// Result register that holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prsp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  prsp_pkg::result_t result,
  output logic              has_space,
  prsp_out_if.source        out_chan
);

  logic              valid_r, valid_nxt;
  prsp_pkg::result_t result_r;

  assign has_space = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.status     = result_r.status;
  assign out_chan.send_query = result_r.send_query;

endmodule

@@ rtl/printer_status_reply_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Printer status reply parser unit
// Polls a label printer and turns its three-line status reply into a code.
// ----------------------------------------------------------------------------
// Each input transaction is a poll request, one received reply byte or one
// centisecond tick, and each produces exactly one result transaction. A poll
// while idle returns send_query = 1 and starts a capture; bytes and ticks then
// return status 0 (in progress) until the third line feed, which returns the
// priority-encoded printer status, or until the reply overruns REPLY_LIMIT
// bytes or the tick count exceeds timeout_ticks, which returns 9 (offline).
// The unit takes one transaction per clock cycle while results drain freely:
// each sits in the input register, then makes one pass through the parser logic
// into the result register. A full result register that is not being drained
// stalls the input register, and the input channel only backs up when both are
// occupied. The timeout register resets to 100 and may be written at any time
// the unit is idle; its write channel is always ready.
`timescale 1ns / 1ps

module printer_status_reply_parser_unit #(
  parameter int unsigned REPLY_LIMIT = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  prsp_in_if.sink     in_chan,
  prsp_out_if.source  out_chan,
  prsp_cfg_if.sink    cfg_chan
);

  logic              item_valid;
  prsp_pkg::item_t   item;
  prsp_pkg::result_t result;
  logic              out_space;
  logic              advance;

  // The register write needs no flow control, so the channel never stalls.
  assign cfg_chan.ready = 1'b1;

  // An item moves through the parser only when the result register can
  // take its result; the capture state updates on exactly those cycles.
  assign advance = item_valid && out_space;

  prsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  prsp_parse_core #(
    .REPLY_LIMIT (REPLY_LIMIT)
  ) u_parse_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_chan.valid),
    .cfg_timeout_ticks (cfg_chan.timeout_ticks),
    .item_valid        (advance),
    .item              (item),
    .result            (result)
  );

  prsp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .has_space (out_space),
    .out_chan  (out_chan)
  );

endmodule

@@ bench/tb_printer_status_reply_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the printer status reply parser unit
// Directed replies for every status, number form, byte limit and timeout, then
// random poll/reply/tick traffic under idling and back-pressure, all checked
// against a cycle-free prediction of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_printer_status_reply_parser_unit;

  localparam int unsigned REPLY_LIMIT  = 100;
  // Two register stages between the input and the result channel.
  localparam int unsigned PIPE_LATENCY = 2;
  localparam int unsigned DRAIN_LIMIT  = 10000;

  // Characters that the number scan treats as leading blanks, besides line feed.
  localparam logic [7:0] BLANK_CHARS [4] = '{
    prsp_pkg::CHAR_SPACE, prsp_pkg::CHAR_TAB, prsp_pkg::CHAR_CR, 8'h0C
  };
  // Any character other than '0' marks a flag as set.
  localparam logic [7:0] FLAG_SET_CHAR = 8'h31;
  localparam logic [7:0] FILL_CHAR     = 8'h2C;

  typedef logic [7:0] reply_bytes_t [$];

  logic clk;
  logic rst_n;

  prsp_in_if  in_if ();
  prsp_out_if out_if ();
  prsp_cfg_if cfg_if ();

  printer_status_reply_parser_unit #(
    .REPLY_LIMIT (REPLY_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Predicted parser state. It is advanced once for every input transaction,
  // at the clock edge where that transaction is accepted.
  // --------------------------------------------------------------------------
  logic                  pred_busy;
  logic [6:0]            pred_len;
  logic [1:0]            pred_lf_count;
  logic [7:0]            pred_flags;
  prsp_pkg::scan_phase_t pred_scan;
  logic                  pred_num_nz;
  logic [15:0]           pred_ticks;
  logic [15:0]           pred_timeout;

  // Expected result transactions, oldest first.
  prsp_pkg::result_t pending_results [$];

  int unsigned send_idle_pct;
  int unsigned ready_stall_pct;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned timeout_writes;
  int unsigned fail_count;
  int unsigned status_seen [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("tb_printer_status_reply_parser_unit failed");
    $finish;
  end

  function automatic void restart_capture();
    pred_len      = '0;
    pred_lf_count = '0;
    pred_flags    = '0;
    pred_scan     = prsp_pkg::SCAN_LEAD;
    pred_num_nz   = 1'b0;
    pred_ticks    = '0;
  endfunction

  // Advances the predicted state by one input transaction and returns the
  // result transaction it must produce.
  function automatic prsp_pkg::result_t predict_reply_step(logic [1:0] kind,
                                                           logic [7:0] c);
    prsp_pkg::result_t r;
    logic              digit;
    logic              blank;
    r.status     = prsp_pkg::ST_BUSY;
    r.send_query = 1'b0;
    digit = (c >= prsp_pkg::CHAR_ZERO) && (c <= prsp_pkg::CHAR_NINE);
    blank = (c == prsp_pkg::CHAR_SPACE) ||
            ((c >= prsp_pkg::CHAR_TAB) && (c <= prsp_pkg::CHAR_CR));
    case (kind)
      prsp_pkg::KIND_POLL: begin
        // A poll while a reply is outstanding is simply ignored.
        if (!pred_busy) begin
          restart_capture();
          pred_busy    = 1'b1;
          r.send_query = 1'b1;
        end
      end
      prsp_pkg::KIND_BYTE: begin
        if (pred_busy && pred_len >= REPLY_LIMIT) begin
          // The reply overran the buffer: the byte is dropped.
          pred_busy = 1'b0;
          r.status  = prsp_pkg::ST_OFFLINE;
        end else if (pred_busy) begin
          for (int i = 0; i < prsp_pkg::NUM_FLAGS; i++) begin
            if (pred_len == prsp_pkg::FLAG_OFFSET[i] && c != prsp_pkg::CHAR_ZERO)
              pred_flags[i] = 1'b1;
          end
          // Number scan: leading blanks, one optional sign, then digits until
          // the first non-digit. Only a nonzero digit matters.
          if (pred_len >= prsp_pkg::NUM_OFFSET) begin
            if (pred_scan == prsp_pkg::SCAN_LEAD && blank) begin
              pred_scan = prsp_pkg::SCAN_LEAD;
            end else if (pred_scan == prsp_pkg::SCAN_LEAD &&
                         (c == prsp_pkg::CHAR_PLUS || c == prsp_pkg::CHAR_MINUS)) begin
              pred_scan = prsp_pkg::SCAN_IN;
            end else if (pred_scan != prsp_pkg::SCAN_DONE) begin
              if (digit) begin
                pred_scan = prsp_pkg::SCAN_IN;
                if (c != prsp_pkg::CHAR_ZERO) pred_num_nz = 1'b1;
              end else begin
                pred_scan = prsp_pkg::SCAN_DONE;
              end
            end
          end
          pred_len = pred_len + 7'd1;
          if (c == prsp_pkg::CHAR_LF) begin
            pred_lf_count = pred_lf_count + 2'd1;
            if (pred_lf_count == prsp_pkg::LINES_NEEDED) begin
              pred_busy = 1'b0;
              if (pred_flags[prsp_pkg::FLAG_NOPAPER])
                r.status = prsp_pkg::ST_NOPAPER;
              else if (pred_flags[prsp_pkg::FLAG_NORIBBON])
                r.status = prsp_pkg::ST_NORIBBON;
              else if (pred_num_nz)
                r.status = prsp_pkg::ST_PENDING;
              else if (pred_flags[prsp_pkg::FLAG_PAUSED])
                r.status = prsp_pkg::ST_PAUSED;
              else if (pred_flags[prsp_pkg::FLAG_BUFFULL])
                r.status = prsp_pkg::ST_BUFFULL;
              else if (|pred_flags[prsp_pkg::FLAG_HW_HI:prsp_pkg::FLAG_HW_LO])
                r.status = prsp_pkg::ST_HWFAULT;
              else if (pred_flags[prsp_pkg::FLAG_HEADOPEN])
                r.status = prsp_pkg::ST_HEADOPEN;
              else
                r.status = prsp_pkg::ST_OK;
            end
          end
        end
      end
      prsp_pkg::KIND_TICK: begin
        if (pred_busy) begin
          if (pred_ticks != prsp_pkg::ELAPSED_MAX) pred_ticks = pred_ticks + 16'd1;
          if (pred_ticks > pred_timeout) begin
            pred_busy = 1'b0;
            r.status  = prsp_pkg::ST_OFFLINE;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready is changed at the falling edge, and every accepted
  // result transaction is compared with the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= (ready_stall_pct == 0) || ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    prsp_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d send_query %0b",
               out_if.status, out_if.send_query);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.send_query !== want.send_query) begin
          $error("send_query mismatch: expected %0b, actual %0b",
                 want.send_query, out_if.send_query);
          fail_count++;
        end
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Valid and payload change at the falling edge; a transaction
  // is taken at the rising edge where ready is seen high, and its result is
  // predicted right there.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] kind, logic [7:0] c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.rx_byte <= c;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_reply_step(kind, c));
    items_sent++;
  endtask

  // Drops valid, then waits for every outstanding result plus the pipeline
  // depth, so that the unit is empty afterwards.
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result transactions never arrived", pending_results.size());
      fail_count++;
      pending_results.delete();
    end
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    wait_drained();
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.timeout_ticks <= ticks;
    do @(posedge clk); while (!cfg_if.ready);
    pred_timeout = ticks;
    timeout_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Sends a poll followed by the reply bytes. Ticks, and now and then a
  // stray poll, are mixed in between the bytes at the given rate.
  task automatic send_reply(reply_bytes_t reply, int unsigned extra_pct);
    send_item(prsp_pkg::KIND_POLL, 8'($urandom_range(255)));
    foreach (reply[i]) begin
      if (extra_pct != 0 && $urandom_range(99) < extra_pct)
        send_item(($urandom_range(9) == 0) ? prsp_pkg::KIND_POLL : prsp_pkg::KIND_TICK,
                  8'($urandom_range(255)));
      send_item(prsp_pkg::KIND_BYTE, reply[i]);
    end
  endtask

  // A 47-byte reply: line feeds at offsets 0, 1 and 46, the chosen flags set,
  // the given text at the number offset and filler elsewhere.
  function automatic reply_bytes_t make_reply(logic [7:0] flag_mask, string num_text);
    reply_bytes_t r;
    for (int i = 0; i < 47; i++) r.push_back(FILL_CHAR);
    for (int i = 0; i < prsp_pkg::NUM_FLAGS; i++)
      r[prsp_pkg::FLAG_OFFSET[i]] = flag_mask[i] ? FLAG_SET_CHAR : prsp_pkg::CHAR_ZERO;
    for (int i = 0; i < num_text.len(); i++) r[prsp_pkg::NUM_OFFSET + i] = num_text[i];
    r[0]  = prsp_pkg::CHAR_LF;
    r[1]  = prsp_pkg::CHAR_LF;
    r[46] = prsp_pkg::CHAR_LF;
    return r;
  endfunction

  // Mostly well-formed replies of random length and content; some are cut
  // short, some overrun the byte limit, some never see their last line feed.
  function automatic reply_bytes_t make_random_reply();
    reply_bytes_t r;
    int           len;
    int           sel;
    int           pos;
    sel = $urandom_range(99);
    if (sel < 10)      len = $urandom_range(3, 45);
    else if (sel < 22) len = $urandom_range(REPLY_LIMIT, REPLY_LIMIT + 15);
    else               len = $urandom_range(46, REPLY_LIMIT - 1);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (sel < 50)      r.push_back(prsp_pkg::CHAR_ZERO);
      else if (sel < 75) r.push_back(FILL_CHAR);
      else if (sel < 96) r.push_back(8'($urandom_range(8'h7E, 8'h20)));
      else               r.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < prsp_pkg::NUM_FLAGS; i++) begin
      if (prsp_pkg::FLAG_OFFSET[i] < len)
        r[prsp_pkg::FLAG_OFFSET[i]] = ($urandom_range(6) == 0) ?
                                      8'($urandom_range(255)) : prsp_pkg::CHAR_ZERO;
    end
    pos = prsp_pkg::NUM_OFFSET;
    repeat ($urandom_range(2)) begin
      if (pos < len) r[pos] = BLANK_CHARS[$urandom_range(3)];
      pos++;
    end
    if ($urandom_range(3) == 0) begin
      if (pos < len) r[pos] = $urandom_range(1) ? prsp_pkg::CHAR_PLUS : prsp_pkg::CHAR_MINUS;
      pos++;
    end
    repeat (($urandom_range(19) == 0) ? $urandom_range(30, 10) : $urandom_range(4, 1)) begin
      if (pos < len)
        r[pos] = ($urandom_range(4) == 0) ?
                 8'(prsp_pkg::CHAR_ZERO + $urandom_range(9, 1)) : prsp_pkg::CHAR_ZERO;
      pos++;
    end
    if (len < REPLY_LIMIT) begin
      repeat (2) r[$urandom_range(len - 2)] = prsp_pkg::CHAR_LF;
      if ($urandom_range(9) != 0) r[len - 1] = prsp_pkg::CHAR_LF;
    end else begin
      repeat ($urandom_range(2)) r[$urandom_range(REPLY_LIMIT - 2)] = prsp_pkg::CHAR_LF;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Bytes, ticks and the unused kind while idle, a poll while waiting, and a
  // reply of three bare line feeds in which no flag offset is ever received.
  task automatic test_idle_items();
    send_item(prsp_pkg::KIND_BYTE, 8'hFF);
    send_item(prsp_pkg::KIND_TICK, 8'h00);
    send_item(prsp_pkg::KIND_NONE, 8'h00);
    send_item(prsp_pkg::KIND_POLL, 8'hFF);
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    send_item(prsp_pkg::KIND_NONE, 8'hFF);
    repeat (3) send_item(prsp_pkg::KIND_BYTE, prsp_pkg::CHAR_LF);
    wait_drained();
  endtask

  // Peels the flags off one at a time in priority order, so that each status
  // shows up while every lower-priority condition is still present.
  task automatic test_status_priority();
    send_reply(make_reply(8'hFF, "7"), 0);
    send_reply(make_reply(8'hFE, "7"), 0);
    send_reply(make_reply(8'h7E, "7"), 0);
    send_reply(make_reply(8'h7E, "0"), 0);
    send_reply(make_reply(8'h7C, "0"), 0);
    send_reply(make_reply(8'h78, "0"), 0);
    send_reply(make_reply(8'h08, "0"), 0);
    send_reply(make_reply(8'h10, "0"), 0);
    send_reply(make_reply(8'h20, "0"), 0);
    send_reply(make_reply(8'h40, "0"), 0);
    send_reply(make_reply(8'h00, "0"), 0);
    wait_drained();
  endtask

  // Forms of the number: blanks, signs, zeros, text after the number, a
  // very long number, and a line feed among the leading blanks that ends
  // the reply before the number starts.
  task automatic test_number_scan();
    send_reply(make_reply(8'h00, "   0009"), 0);
    send_reply(make_reply(8'h00, "\t\v\f\r 0"), 0);
    send_reply(make_reply(8'h00, "-0"), 0);
    send_reply(make_reply(8'h00, "+5"), 0);
    send_reply(make_reply(8'h00, "--5"), 0);
    send_reply(make_reply(8'h00, "- 5"), 0);
    send_reply(make_reply(8'h00, "0,5"), 0);
    send_reply(make_reply(8'h00, "0000000000000000000000000000003"), 0);
    send_reply(make_reply(8'h00, "\n5"), 0);
    wait_drained();
  endtask

  // A reply that fills the buffer without its third line feed goes offline
  // on the next byte; one whose third line feed is the last byte allowed
  // still gives its status.
  task automatic test_reply_limit();
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    for (int i = 0; i < REPLY_LIMIT; i++)
      send_item(prsp_pkg::KIND_BYTE,
                (i == 10 || i == 60) ? prsp_pkg::CHAR_LF : prsp_pkg::CHAR_ZERO);
    send_item(prsp_pkg::KIND_BYTE, prsp_pkg::CHAR_LF);
    send_item(prsp_pkg::KIND_BYTE, prsp_pkg::CHAR_LF);
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    for (int i = 0; i < REPLY_LIMIT; i++)
      send_item(prsp_pkg::KIND_BYTE, (i == 10 || i == 60 || i == REPLY_LIMIT - 1) ?
                                     prsp_pkg::CHAR_LF : prsp_pkg::CHAR_ZERO);
    wait_drained();
  endtask

  // The reset timeout, a timeout of one tick, and the longest one, which a long
  // run of ticks stays well below.
  task automatic test_timeout();
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    repeat (int'(prsp_pkg::TIMEOUT_RESET) + 1) send_item(prsp_pkg::KIND_TICK, 8'h00);
    write_timeout(16'd1);
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    repeat (3) send_item(prsp_pkg::KIND_TICK, 8'h00);
    write_timeout(prsp_pkg::ELAPSED_MAX);
    send_item(prsp_pkg::KIND_POLL, 8'h00);
    repeat (2 * int'(prsp_pkg::TIMEOUT_RESET)) send_item(prsp_pkg::KIND_TICK, 8'hFF);
    repeat (3) send_item(prsp_pkg::KIND_BYTE, prsp_pkg::CHAR_LF);
    wait_drained();
  endtask

  task automatic run_traffic_phase(int unsigned n_items, int unsigned idle_pct,
                                   int unsigned stall_pct, logic [15:0] ticks);
    int unsigned first;
    write_timeout(ticks);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(99) < 85) begin
        send_reply(make_random_reply(), $urandom_range(12));
      end else begin
        repeat ($urandom_range(6, 1))
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
    wait_drained();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
  endtask

  // Random traffic across idling and back-pressure patterns and timeout settings.
  task automatic test_random_traffic();
    run_traffic_phase(100, 0, 0, prsp_pkg::TIMEOUT_RESET);
    run_traffic_phase(100, 58, 0, prsp_pkg::ELAPSED_MAX);
    run_traffic_phase(100, 0, 58, 16'($urandom_range(60, 2)));
    run_traffic_phase(100, 34, 34, 16'd1);
    run_traffic_phase(100, 0, 0, 16'($urandom_range(16'hFFFF, 1)));
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.kind           = prsp_pkg::KIND_POLL;
    in_if.rx_byte        = 8'h00;
    cfg_if.valid         = 1'b0;
    cfg_if.timeout_ticks = 16'h0000;
    send_idle_pct        = 0;
    ready_stall_pct      = 0;
    items_sent           = 0;
    results_checked      = 0;
    timeout_writes       = 0;
    fail_count           = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    pred_busy    = 1'b0;
    pred_timeout = prsp_pkg::TIMEOUT_RESET;
    restart_capture();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_status_priority();
    test_number_scan();
    test_reply_limit();
    test_timeout();
    test_random_traffic();
    wait_drained();

    $display("Covered %0d input transactions and %0d results with %0d timeout writes.",
             items_sent, results_checked, timeout_writes);
    $display("Status counts: busy %0d ok %0d paper %0d ribbon %0d pending %0d",
             status_seen[prsp_pkg::ST_BUSY], status_seen[prsp_pkg::ST_OK],
             status_seen[prsp_pkg::ST_NOPAPER], status_seen[prsp_pkg::ST_NORIBBON],
             status_seen[prsp_pkg::ST_PENDING],
             " paused %0d buffer %0d fault %0d head %0d offline %0d",
             status_seen[prsp_pkg::ST_PAUSED], status_seen[prsp_pkg::ST_BUFFULL],
             status_seen[prsp_pkg::ST_HWFAULT], status_seen[prsp_pkg::ST_HEADOPEN],
             status_seen[prsp_pkg::ST_OFFLINE]);
    if (fail_count == 0) begin
      $display("tb_printer_status_reply_parser_unit passed");
    end else begin
      $display("tb_printer_status_reply_parser_unit failed");
    end
    $finish;
  end

endmodule
